// ===== design/pcmpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM PWM player package
// Shared constants, command codes, register indexes and the control and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcmpwm_pkg;

  localparam int DEF_STORE_DEPTH = 512;

  // Command codes carried in the cmd field of a request.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_PUSH   = 2'd1;
  localparam logic [1:0] CMD_LOAD   = 2'd2;
  localparam logic [1:0] CMD_REWIND = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUNNING     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LENGTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 3'd6;

  localparam logic [7:0]  MIDSCALE      = 8'd128;
  localparam logic [15:0] FULL_SCALE_SQ = 16'(255 * 255);

  // Division by FULL_SCALE_SQ is a multiply by this reciprocal, a shift
  // right by RECIP_SHIFT and one correction step.
  localparam int          RECIP_SHIFT = 47;
  localparam logic [31:0] RECIP       = 32'((64'd1 << RECIP_SHIFT) / 64'(FULL_SCALE_SQ));

  typedef struct packed {
    logic take;      // request accepted this cycle
    logic mul1;      // sample scaling and period quotient check
    logic corr1;     // period quotient correction
    logic mul2;      // partial products of the duty
    logic mul3;      // reciprocal multiply of the remainder product
    logic mul4;      // back-multiply for the remainder quotient check
    logic load_out;  // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
  } ctrl_stat_t;

endpackage

// ===== design/pcmpwm_if.sv =====
// ----------------------------------------------------------------------------
// PCM PWM player channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pcmpwm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] sample_byte;
  logic [8:0] clip_index;

  modport source (output valid, cmd, sample_byte, clip_index, input ready);
  modport sink   (input valid, cmd, sample_byte, clip_index, output ready);
endinterface

interface pcmpwm_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sample_out;
  logic [31:0] duty_pulse;
  logic        duty_valid;
  logic        push_accepted;
  logic [8:0]  fifo_used;

  modport source (output valid, sample_out, duty_pulse, duty_valid, push_accepted,
                  fifo_used, input ready);
  modport sink   (input valid, sample_out, duty_pulse, duty_valid, push_accepted,
                  fifo_used, output ready);
endinterface

interface pcmpwm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pcmpwm_pkg::CFG_IDX_W-1:0]  index;
  logic [pcmpwm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/pcmpwm_ram.sv =====
// ----------------------------------------------------------------------------
// PCM PWM player RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pcmpwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcmpwm_pkg::DEF_STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/pcmpwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// PCM PWM player controller
// Sequences one request at a time through the duty computation steps and
// owns the request and result handshakes.
// ----------------------------------------------------------------------------
module pcmpwm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  pcmpwm_pkg::ctrl_stat_t stat,
  output pcmpwm_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL1  = 3'd1;
  localparam logic [2:0] ST_CORR1 = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_MUL3  = 3'd4;
  localparam logic [2:0] ST_MUL4  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;
  logic       out_valid_next;
  logic       out_free;

  // The result register may be reloaded in the cycle its content is taken.
  assign out_free  = !out_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = stat.is_tick ? ST_MUL1 : ST_FIN;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_CORR1;
      end
      ST_CORR1: begin
        cmd.corr1  = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = ST_MUL4;
      end
      ST_MUL4: begin
        cmd.mul4   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/pcmpwm_dp.sv =====
// ----------------------------------------------------------------------------
// PCM PWM player datapath
// Configuration registers, sample store with FIFO and clip pointers, the
// duty arithmetic and the result register.
// ----------------------------------------------------------------------------
module pcmpwm_dp #(
  parameter int STORE_DEPTH = pcmpwm_pkg::DEF_STORE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pcmpwm_pkg::ctrl_cmd_t             cmd,
  output pcmpwm_pkg::ctrl_stat_t            stat,
  input  logic                              cfg_we,
  input  logic [pcmpwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcmpwm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]                        req_cmd,
  input  logic [7:0]                        req_sample_byte,
  input  logic [8:0]                        req_clip_index,
  output logic [7:0]                        sample_out,
  output logic [31:0]                       duty_pulse,
  output logic                              duty_valid,
  output logic                              push_accepted,
  output logic [8:0]                        fifo_used
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(STORE_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(STORE_DEPTH - 1);
  localparam int RS = pcmpwm_pkg::RECIP_SHIFT;

  // Configuration registers.
  logic        enable;
  logic        running;
  logic        stream_mode;
  logic [7:0]  volume;
  logic [31:0] pwm_period;
  logic [9:0]  clip_length;
  logic        loop_enable;

  // Store pointers.
  logic [AW-1:0] write_pointer;
  logic [AW-1:0] read_pointer;
  logic [9:0]    clip_position;

  // Item context latched on acceptance.
  logic tick_q;
  logic run_q;
  logic en_q;
  logic have_q;
  logic acc_q;

  // Arithmetic pipeline registers.
  logic [16:0] q1c_q;
  logic [7:0]  samp_q;
  logic [15:0] p_q;
  logic [32:0] e1_q;
  logic [16:0] q_q;
  logic [15:0] r_q;
  logic [32:0] a_q;
  logic [31:0] y_q;
  logic [16:0] q2c_q;
  logic [32:0] e2_q;

  logic [AW-1:0]   count;
  logic [AW:0]     count_wrap;
  logic [AW+8:0]   count_ext;
  logic [AW+9:0]   clip_ext;
  logic [AW+8:0]   index_ext;
  logic [AW-1:0]   clip_addr;
  logic [AW-1:0]   index_addr;
  logic            fifo_nonempty;
  logic            clip_ok;
  logic [9:0]      clip_inc;
  logic            push_ok;
  logic            load_ok;
  logic            tick_run;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  logic [7:0]      sample_sel;
  logic [63:0]     prod_period;
  logic [63:0]     prod_rem;
  logic [32:0]     r0;
  logic [32:0]     r2;
  logic [16:0]     fq;
  logic [32:0]     duty_sum;

  assign stat.is_tick = (req_cmd == pcmpwm_pkg::CMD_TICK);

  // FIFO fill level, with the wrapped case when the read pointer leads.
  assign count_wrap = {1'b0, write_pointer} + DEPTH_W - {1'b0, read_pointer};
  assign count      = (write_pointer >= read_pointer) ? (write_pointer - read_pointer)
                                                      : count_wrap[AW-1:0];
  assign count_ext  = {9'b0, count};

  assign clip_ext   = {{AW{1'b0}}, clip_position};
  assign clip_addr  = clip_ext[AW-1:0];
  assign index_ext  = {{AW{1'b0}}, req_clip_index};
  assign index_addr = index_ext[AW-1:0];

  assign fifo_nonempty = (write_pointer != read_pointer);
  assign clip_ok       = (clip_position < clip_length) &&
                         (32'(clip_position) < 32'(STORE_DEPTH));
  assign clip_inc      = clip_position + 10'd1;
  assign tick_run      = stat.is_tick && running;
  assign push_ok       = (req_cmd == pcmpwm_pkg::CMD_PUSH) && stream_mode && (count != LAST);
  assign load_ok       = (req_cmd == pcmpwm_pkg::CMD_LOAD) &&
                         (32'(req_clip_index) < 32'(STORE_DEPTH));

  assign ram_we    = cmd.take && (push_ok || load_ok);
  assign ram_waddr = push_ok ? write_pointer : index_addr;
  assign ram_raddr = stream_mode ? read_pointer : clip_addr;

  pcmpwm_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (req_sample_byte),
    .rd_en   (cmd.take),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      running     <= 1'b0;
      stream_mode <= 1'b0;
      volume      <= '0;
      pwm_period  <= '0;
      clip_length <= '0;
      loop_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcmpwm_pkg::REG_ENABLE:      enable      <= cfg_data[0];
        pcmpwm_pkg::REG_RUNNING:     running     <= cfg_data[0];
        pcmpwm_pkg::REG_STREAM_MODE: stream_mode <= cfg_data[0];
        pcmpwm_pkg::REG_VOLUME:      volume      <= cfg_data[7:0];
        pcmpwm_pkg::REG_PWM_PERIOD:  pwm_period  <= cfg_data[31:0];
        pcmpwm_pkg::REG_CLIP_LENGTH: clip_length <= cfg_data[9:0];
        pcmpwm_pkg::REG_LOOP_ENABLE: loop_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      clip_position <= '0;
    end else if (cmd.take) begin
      if (req_cmd == pcmpwm_pkg::CMD_REWIND) begin
        write_pointer <= '0;
        read_pointer  <= '0;
        clip_position <= '0;
      end else if (push_ok) begin
        write_pointer <= (write_pointer == LAST) ? '0 : write_pointer + 1'b1;
      end else if (tick_run && stream_mode && fifo_nonempty) begin
        read_pointer <= (read_pointer == LAST) ? '0 : read_pointer + 1'b1;
      end else if (tick_run && !stream_mode && clip_ok) begin
        clip_position <= (clip_inc == clip_length && loop_enable) ? '0 : clip_inc;
      end
    end
  end

  // The period quotient by the full-scale square starts in the accept cycle.
  assign prod_period = 64'(pwm_period) * 64'(pcmpwm_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      tick_q <= stat.is_tick;
      run_q  <= running;
      en_q   <= enable;
      have_q <= stream_mode ? fifo_nonempty : clip_ok;
      acc_q  <= push_ok;
      q1c_q  <= prod_period[63:RS];
    end
  end

  assign sample_sel = have_q ? ram_rdata : pcmpwm_pkg::MIDSCALE;

  // duty = p * period / F is split as p * q + floor(p * r / F),
  // where period = q * F + r and p = sample * volume.
  assign r0 = {1'b0, pwm_period} - e1_q;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      samp_q <= sample_sel;
      p_q    <= 16'(sample_sel) * 16'(volume);
      e1_q   <= 33'(q1c_q) * 33'(pcmpwm_pkg::FULL_SCALE_SQ);
    end
    if (cmd.corr1) begin
      if (r0 >= 33'(pcmpwm_pkg::FULL_SCALE_SQ)) begin
        q_q <= q1c_q + 17'd1;
        r_q <= 16'(r0 - 33'(pcmpwm_pkg::FULL_SCALE_SQ));
      end else begin
        q_q <= q1c_q;
        r_q <= r0[15:0];
      end
    end
    if (cmd.mul2) begin
      a_q <= 33'(p_q) * 33'(q_q);
      y_q <= 32'(p_q) * 32'(r_q);
    end
    if (cmd.mul3) begin
      q2c_q <= prod_rem[63:RS];
    end
    if (cmd.mul4) begin
      e2_q <= 33'(q2c_q) * 33'(pcmpwm_pkg::FULL_SCALE_SQ);
    end
  end

  assign prod_rem = 64'(y_q) * 64'(pcmpwm_pkg::RECIP);
  assign r2       = {1'b0, y_q} - e2_q;
  assign fq       = q2c_q + 17'(r2 >= 33'(pcmpwm_pkg::FULL_SCALE_SQ));
  assign duty_sum = a_q + 33'(fq);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sample_out    <= (tick_q && run_q) ? samp_q : 8'd0;
      duty_pulse    <= (tick_q && run_q && en_q) ? duty_sum[31:0] : 32'd0;
      duty_valid    <= tick_q && run_q && en_q;
      push_accepted <= acc_q;
      fifo_used     <= count_ext[8:0];
    end
  end

endmodule

// ===== design/pcm_sample_fifo_pwm_player_top.sv =====
// ----------------------------------------------------------------------------
// PCM sample FIFO PWM player
// Top level: 8-bit PCM player with a shared ring FIFO / clip store that turns
// each sample tick into a PWM pulse width.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. Push, clip load and rewind requests
// go from acceptance through the final load state before the next request is
// accepted; a sample tick first passes the registered multiply and correction
// steps MUL1, CORR1, MUL2, MUL3, MUL4 that divide sample * volume * pwm_period
// by 65025. The result register lets the next request be accepted while a
// result waits; the block only stalls when a new result is ready and the
// previous one has not been taken. Configuration writes are accepted every
// cycle and must only be issued while the block is idle.
module pcm_sample_fifo_pwm_player_top #(
  parameter int STORE_DEPTH = pcmpwm_pkg::DEF_STORE_DEPTH
) (
  input logic         clk,
  input logic         rst,
  pcmpwm_req_if.sink  req,
  pcmpwm_rsp_if.source rsp,
  pcmpwm_cfg_if.sink  cfg
);

  pcmpwm_pkg::ctrl_cmd_t  ctrl_cmd;
  pcmpwm_pkg::ctrl_stat_t ctrl_stat;

  assign cfg.ready = 1'b1;

  pcmpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (ctrl_stat),
    .cmd       (ctrl_cmd)
  );

  pcmpwm_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (ctrl_cmd),
    .stat            (ctrl_stat),
    .cfg_we          (cfg.valid && cfg.ready),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .req_cmd         (req.cmd),
    .req_sample_byte (req.sample_byte),
    .req_clip_index  (req.clip_index),
    .sample_out      (rsp.sample_out),
    .duty_pulse      (rsp.duty_pulse),
    .duty_valid      (rsp.duty_valid),
    .push_accepted   (rsp.push_accepted),
    .fifo_used       (rsp.fifo_used)
  );

  // Only one request is in flight: an accepted request closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

  // A new result is never loaded in the same cycle a request is taken.
  a_no_load_on_take: assert property (@(posedge clk) disable iff (rst)
    !(ctrl_cmd.take && ctrl_cmd.load_out))
    else $error("result load overlaps request acceptance");

  // Without a duty update the pulse width reads zero.
  a_duty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.duty_valid) |-> (rsp.duty_pulse == 32'd0))
    else $error("duty pulse nonzero without duty update");

  // An accepted push is never a tick result.
  a_push_no_sample: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.push_accepted) |-> (!rsp.duty_valid && rsp.sample_out == 8'd0))
    else $error("push result carries tick fields");

endmodule
